// ===== sv/pta_pkg.sv =====
// package for the polynomial term accumulator
// mode codes, store selects, widths and the sequencer state type; no dependencies
package pta_pkg;

	localparam int MaxExp    = 31;
	localparam int BaseDepth = MaxExp + 1;
	localparam int ProdDepth = 2 * MaxExp + 1;
	localparam int BaseAw    = $clog2(BaseDepth);
	localparam int ProdAw    = $clog2(ProdDepth);
	localparam int CoefW     = 32;

	typedef logic [CoefW-1:0]  coef_t;
	typedef logic [BaseAw-1:0] base_addr_t;
	typedef logic [ProdAw-1:0] prod_addr_t;

	typedef enum logic [2:0] {
		MODE_INSERT = 3'd0,
		MODE_ADD    = 3'd1,
		MODE_MUL    = 3'd2,
		MODE_LIST   = 3'd3,
		MODE_COUNT  = 3'd4,
		MODE_CLEAR  = 3'd5
	} mode_t;

	typedef enum logic [1:0] {
		SEL_A    = 2'd0,
		SEL_B    = 2'd1,
		SEL_SUM  = 2'd2,
		SEL_PROD = 2'd3
	} sel_t;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_INS_RD,
		ST_INS_WR,
		ST_ADD_RD,
		ST_ADD_WR,
		ST_MUL_RD,
		ST_MUL_MP,
		ST_MUL_WR,
		ST_SCAN_RD,
		ST_SCAN_CHK,
		ST_OUT,
		ST_WIPE
	} state_t;

endpackage

// ===== sv/polynomial_term_accumulator.sv =====
// polynomial term accumulator top level: four coefficient memories and a sequencer
// depends on pta_pkg
//
// Usage: one input channel (valid/stall) carries a command; results leave on the
// output channel (out_valid/out_stall), one term per transfer, last on the final.
// Insert adds term_coef into A or B at term_exp; add accumulates A+B into the sum
// store, multiply accumulates A*B into the product store, both then list that store.
// List emits nonzero terms in descending exponent order (one empty marker if none),
// count gives one result, clear wipes one store.
// The block takes one command at a time. Add reads and writes every base entry,
// multiply reads, multiplies and writes for every pair of A and B entries, and
// list or count scans every entry of the store, waiting on any output stall.
// A found term is held back until the next one is found or the scan ends, so
// the final term can carry last.
// Each accumulate is read, then modified, then written through the one read and one
// write port of each memory, so no forwarding is needed.
// After reset a clearing pass zeroes all memories; no command is accepted during
// it. While the receiver stalls, the held result stays put and the scan waits.
module polynomial_term_accumulator (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                valid,
	output logic                stall,
	input  logic [2:0]          mode,
	input  logic [1:0]          list_id,
	input  logic signed [31:0]  term_coef,
	input  logic [4:0]          term_exp,
	output logic                out_valid,
	input  logic                out_stall,
	output logic signed [31:0]  out_coef,
	output logic [5:0]          out_exp,
	output logic [5:0]          term_count,
	output logic                is_empty,
	output logic                last
);
	import pta_pkg::*;

	// memories
	coef_t mem_a [BaseDepth];
	coef_t mem_b [BaseDepth];
	coef_t mem_s [BaseDepth];
	coef_t mem_p [ProdDepth];

	state_t state_q, state_d;
	logic [2:0]   mode_q;
	logic [1:0]   sel_q;
	coef_t        coef_q;
	base_addr_t   iexp_q;
	logic [BaseAw:0] i_q, j_q;
	logic [ProdAw:0] e_q;
	logic [5:0]   cnt_q;
	coef_t        rd_a, rd_b, rd_s, rd_p, prod_q, term_q;
	logic [5:0]   texp_q;
	logic         found_q;
	logic         fin_q;
	logic         ov_q;
	logic signed [31:0] oc_q;
	logic [5:0]   oe_q, otc_q;
	logic         oem_q, ol_q;

	logic accept, out_free;
	logic [ProdAw:0] depth;
	logic [ProdAw:0] mul_idx;
	coef_t cur;
	logic  done_i, done_j, scan_end;
	logic  swap_term;
	logic [ProdAw:0] next_nz;

	assign accept   = valid && !stall;
	assign out_free = !ov_q || !out_stall;
	assign stall    = (state_q != ST_IDLE);
	assign depth    = (sel_q == SEL_PROD) ? (ProdAw+1)'(ProdDepth) : (ProdAw+1)'(BaseDepth);
	assign mul_idx  = (ProdAw+1)'(i_q) + (ProdAw+1)'(j_q);
	assign done_i   = (i_q == (BaseAw+1)'(BaseDepth - 1));
	assign done_j   = (j_q == (BaseAw+1)'(BaseDepth - 1));
	assign scan_end = (e_q == '0);

	// scanned value of the selected store
	always_comb begin
		case (sel_q)
			SEL_A:   cur = rd_a;
			SEL_B:   cur = rd_b;
			SEL_SUM: cur = rd_s;
			default: cur = rd_p;
		endcase
	end
	assign next_nz = e_q - 1'b1;

	// a new term while one is held: emit the held one first
	assign swap_term = (mode_q != MODE_COUNT) && (cur != '0) && found_q;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR: if (e_q == (ProdAw+1)'(ProdDepth - 1)) state_d = ST_IDLE;
			ST_IDLE: begin
				if (accept) begin
					case (mode)
						MODE_INSERT: state_d = (list_id[1] == 1'b0) ? ST_INS_RD : ST_IDLE;
						MODE_ADD:    state_d = ST_ADD_RD;
						MODE_MUL:    state_d = ST_MUL_RD;
						MODE_LIST, MODE_COUNT: state_d = ST_SCAN_RD;
						MODE_CLEAR:  state_d = ST_WIPE;
						default:     state_d = ST_IDLE;
					endcase
				end
			end
			ST_INS_RD: state_d = ST_INS_WR;
			ST_INS_WR: state_d = ST_IDLE;
			ST_ADD_RD: state_d = ST_ADD_WR;
			ST_ADD_WR: state_d = done_i ? ST_SCAN_RD : ST_ADD_RD;
			ST_MUL_RD: state_d = ST_MUL_MP;
			ST_MUL_MP: state_d = ST_MUL_WR;
			ST_MUL_WR: state_d = (done_i && done_j) ? ST_SCAN_RD : ST_MUL_RD;
			ST_SCAN_RD: state_d = ST_SCAN_CHK;
			ST_SCAN_CHK: begin
				if (swap_term || scan_end) state_d = ST_OUT;
				else state_d = ST_SCAN_RD;
			end
			ST_OUT: begin
				if (out_free) begin
					if (fin_q) state_d = ST_IDLE;
					else if (scan_end) state_d = ST_OUT;
					else state_d = ST_SCAN_RD;
				end
			end
			ST_WIPE: if (e_q == depth - 1'b1) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// memory read ports, one registered read per memory
	always_ff @(posedge clk) begin
		rd_a <= mem_a[(state_q == ST_MUL_RD) ? i_q[BaseAw-1:0]
			: (state_q == ST_INS_RD) ? iexp_q : (state_q == ST_ADD_RD) ? i_q[BaseAw-1:0]
			: e_q[BaseAw-1:0]];
		rd_b <= mem_b[(state_q == ST_MUL_RD) ? j_q[BaseAw-1:0]
			: (state_q == ST_INS_RD) ? iexp_q : (state_q == ST_ADD_RD) ? i_q[BaseAw-1:0]
			: e_q[BaseAw-1:0]];
		rd_s <= mem_s[(state_q == ST_ADD_RD) ? i_q[BaseAw-1:0] : e_q[BaseAw-1:0]];
		rd_p <= mem_p[(state_q == ST_MUL_RD || state_q == ST_MUL_MP) ? mul_idx[ProdAw-1:0]
			: (e_q[ProdAw-1:0] < ProdAw'(ProdDepth)) ? e_q[ProdAw-1:0] : '0];
	end

	// product of one coefficient pair, registered before the accumulate
	always_ff @(posedge clk) begin
		if (state_q == ST_MUL_MP) prod_q <= coef_t'(rd_a * rd_b);
	end

	// memory writes
	always_ff @(posedge clk) begin
		if (state_q == ST_CLEAR) begin
			if (e_q < (ProdAw+1)'(BaseDepth)) begin
				mem_a[e_q[BaseAw-1:0]] <= '0;
				mem_b[e_q[BaseAw-1:0]] <= '0;
				mem_s[e_q[BaseAw-1:0]] <= '0;
			end
			mem_p[e_q[ProdAw-1:0]] <= '0;
		end
		if (state_q == ST_INS_WR) begin
			if (sel_q == SEL_A) mem_a[iexp_q] <= rd_a + coef_q;
			else mem_b[iexp_q] <= rd_b + coef_q;
		end
		if (state_q == ST_ADD_WR) mem_s[i_q[BaseAw-1:0]] <= rd_s + rd_a + rd_b;
		if (state_q == ST_MUL_WR) mem_p[mul_idx[ProdAw-1:0]] <= rd_p + prod_q;
		if (state_q == ST_WIPE) begin
			case (sel_q)
				SEL_A:   mem_a[e_q[BaseAw-1:0]] <= '0;
				SEL_B:   mem_b[e_q[BaseAw-1:0]] <= '0;
				SEL_SUM: mem_s[e_q[BaseAw-1:0]] <= '0;
				default: mem_p[e_q[ProdAw-1:0]] <= '0;
			endcase
		end
	end

	// command capture and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			e_q     <= '0;
			i_q     <= '0;
			j_q     <= '0;
			cnt_q   <= '0;
			found_q <= 1'b0;
			fin_q   <= 1'b0;
			mode_q  <= '0;
			sel_q   <= '0;
		end else begin
			state_q <= state_d;
			unique case (state_q)
				ST_CLEAR: e_q <= e_q + 1'b1;
				ST_IDLE: if (accept) begin
					mode_q  <= mode;
					sel_q   <= (mode == MODE_ADD) ? SEL_SUM
						: (mode == MODE_MUL) ? SEL_PROD : list_id;
					i_q     <= '0;
					j_q     <= '0;
					cnt_q   <= '0;
					found_q <= 1'b0;
					fin_q   <= 1'b0;
					if (mode == MODE_LIST || mode == MODE_COUNT)
						e_q <= (list_id == SEL_PROD) ? (ProdAw+1)'(ProdDepth - 1)
							: (ProdAw+1)'(BaseDepth - 1);
					else e_q <= '0;
				end
				ST_ADD_WR: begin
					i_q <= i_q + 1'b1;
					e_q <= (ProdAw+1)'(BaseDepth - 1);
				end
				ST_MUL_WR: begin
					j_q <= j_q + 1'b1;
					if (done_j) begin
						j_q <= '0;
						i_q <= i_q + 1'b1;
					end
					e_q <= (ProdAw+1)'(ProdDepth - 1);
				end
				ST_SCAN_CHK: begin
					if (cur != '0) begin
						cnt_q <= cnt_q + 1'b1;
						if (mode_q != MODE_COUNT) found_q <= 1'b1;
					end
					fin_q <= !swap_term && scan_end;
					if (!swap_term && !scan_end) e_q <= next_nz;
				end
				ST_OUT: if (out_free && !fin_q) begin
					if (scan_end) fin_q <= 1'b1;
					else e_q <= next_nz;
				end
				ST_WIPE: e_q <= e_q + 1'b1;
				default: ;
			endcase
		end
	end

	// payload capture for insert and the held list term
	always_ff @(posedge clk) begin
		if (accept) begin
			coef_q <= term_coef;
			iexp_q <= term_exp;
		end
		if (state_q == ST_SCAN_CHK && mode_q != MODE_COUNT && cur != '0 && !found_q) begin
			term_q <= cur;
			texp_q <= 6'(e_q);
		end
		if (state_q == ST_OUT && out_free && !fin_q) begin
			term_q <= cur;
			texp_q <= 6'(e_q);
		end
	end

	// output register; a held term stays until transferred
	logic emit;
	assign emit = (state_q == ST_OUT) && out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
		end else if (out_free) begin
			ov_q <= emit;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			if (mode_q == MODE_COUNT) begin
				oc_q  <= '0;
				oe_q  <= '0;
				otc_q <= cnt_q;
				oem_q <= (cnt_q == '0);
				ol_q  <= 1'b1;
			end else if (!found_q) begin
				oc_q  <= '0;
				oe_q  <= '0;
				otc_q <= '0;
				oem_q <= 1'b1;
				ol_q  <= 1'b1;
			end else begin
				oc_q  <= term_q;
				oe_q  <= texp_q;
				otc_q <= '0;
				oem_q <= 1'b0;
				ol_q  <= fin_q;
			end
		end
	end

	assign out_valid  = ov_q;
	assign out_coef   = oc_q;
	assign out_exp    = oe_q;
	assign term_count = otc_q;
	assign is_empty   = oem_q;
	assign last       = ol_q;

	// checks
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> !stall == 1'b0) else $error("accept while busy");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(ov_q && out_stall) |=> (ov_q && $stable(oc_q) && $stable(oe_q)))
		else $error("held result changed");
	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MUL_WR) |-> (mul_idx < (ProdAw+1)'(ProdDepth)))
		else $error("product index out of range");
	a_empty_last: assert property (@(posedge clk) disable iff (!arst_n)
		(ov_q && oem_q) |-> ol_q) else $error("empty marker without last");

endmodule

// ===== tb/sv/polynomial_term_accumulator_test.sv =====
// testbench for the polynomial term accumulator: queued driver, monitor and predictor
// depends on pta_pkg and polynomial_term_accumulator
module polynomial_term_accumulator_test;
	import pta_pkg::*;

	typedef struct {
		logic [2:0]  mode;
		logic [1:0]  sel;
		logic [31:0] coef;
		logic [4:0]  exp;
	} cmd_t;

	typedef struct {
		logic [31:0] coef;
		logic [5:0]  exp;
		logic [5:0]  count;
		logic        empty;
		logic        last;
	} term_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic valid = 1'b0;
	logic stall;
	logic [2:0] mode = '0;
	logic [1:0] list_id = '0;
	logic signed [31:0] term_coef = '0;
	logic [4:0] term_exp = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [31:0] out_coef;
	logic [5:0] out_exp;
	logic [5:0] term_count;
	logic is_empty;
	logic last;

	cmd_t  pending[$];
	term_t expected_terms[$];
	int    errors = 0;
	int    send_idle_pct = 0;
	int    recv_stall_pct = 0;
	bit    hold_recv = 0;

	// shadow stores
	logic [31:0] shadow_a[BaseDepth];
	logic [31:0] shadow_b[BaseDepth];
	logic [31:0] shadow_sum[BaseDepth];
	logic [31:0] shadow_prod[ProdDepth];

	polynomial_term_accumulator dut (.*);

	always #4 clk = ~clk;

	// list nonzero terms of a shadow store, descending
	task automatic queue_listing(input logic [1:0] sel);
		int depth;
		int n;
		logic [31:0] c;
		term_t t;
		depth = (sel == SEL_PROD) ? ProdDepth : BaseDepth;
		n = 0;
		for (int e = depth - 1; e >= 0; e--) begin
			case (sel)
				SEL_A:   c = shadow_a[e];
				SEL_B:   c = shadow_b[e];
				SEL_SUM: c = shadow_sum[e];
				default: c = shadow_prod[e];
			endcase
			if (c != 0) begin
				if (n > 0) expected_terms[$].last = 1'b0;
				t = '{c, 6'(e), 6'd0, 1'b0, 1'b1};
				expected_terms.push_back(t);
				n++;
			end
		end
		if (n == 0) begin
			t = '{32'd0, 6'd0, 6'd0, 1'b1, 1'b1};
			expected_terms.push_back(t);
		end
	endtask

	// predicts the results caused by one accepted command
	task automatic predict_command(input cmd_t c);
		int n;
		int depth;
		logic [31:0] v;
		term_t t;
		case (c.mode)
			MODE_INSERT: begin
				if (c.sel == SEL_A) shadow_a[c.exp] += c.coef;
				else if (c.sel == SEL_B) shadow_b[c.exp] += c.coef;
			end
			MODE_ADD: begin
				for (int i = 0; i < BaseDepth; i++)
					shadow_sum[i] += shadow_a[i] + shadow_b[i];
				queue_listing(SEL_SUM);
			end
			MODE_MUL: begin
				for (int i = 0; i < BaseDepth; i++)
					for (int j = 0; j < BaseDepth; j++)
						shadow_prod[i + j] += shadow_a[i] * shadow_b[j];
				queue_listing(SEL_PROD);
			end
			MODE_LIST: queue_listing(c.sel);
			MODE_COUNT: begin
				n = 0;
				depth = (c.sel == SEL_PROD) ? ProdDepth : BaseDepth;
				for (int e = 0; e < depth; e++) begin
					case (c.sel)
						SEL_A:   v = shadow_a[e];
						SEL_B:   v = shadow_b[e];
						SEL_SUM: v = shadow_sum[e];
						default: v = shadow_prod[e];
					endcase
					if (v != 0) n++;
				end
				t = '{32'd0, 6'd0, 6'(n), n == 0, 1'b1};
				expected_terms.push_back(t);
			end
			MODE_CLEAR: begin
				for (int e = 0; e < ProdDepth; e++) begin
					if (e < BaseDepth) begin
						if (c.sel == SEL_A) shadow_a[e] = 0;
						if (c.sel == SEL_B) shadow_b[e] = 0;
						if (c.sel == SEL_SUM) shadow_sum[e] = 0;
					end
					if (c.sel == SEL_PROD) shadow_prod[e] = 0;
				end
			end
			default: ;
		endcase
	endtask

	// driver: offers queued commands, predicts on each transfer
	always @(posedge clk) begin
		if (arst_n) begin
			if (valid && !stall) predict_command('{mode, list_id, term_coef, term_exp});
			if (!valid || !stall) begin
				if (pending.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
					cmd_t c;
					c = pending.pop_front();
					valid <= 1'b1;
					mode <= c.mode;
					list_id <= c.sel;
					term_coef <= c.coef;
					term_exp <= c.exp;
				end else begin
					valid <= 1'b0;
				end
			end
		end
	end

	// monitor: checks each result transfer against the oldest prediction
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (expected_terms.size() == 0) begin
					$display("%0t: unexpected result coef %h exp %0d", $time, out_coef, out_exp);
					errors++;
				end else begin
					term_t t;
					t = expected_terms.pop_front();
					if (out_coef !== t.coef) begin
						$display("%0t: out_coef expected %h actual %h", $time, t.coef, out_coef);
						errors++;
					end
					if (out_exp !== t.exp) begin
						$display("%0t: out_exp expected %0d actual %0d", $time, t.exp, out_exp);
						errors++;
					end
					if (term_count !== t.count) begin
						$display("%0t: term_count expected %0d actual %0d", $time, t.count,
							term_count);
						errors++;
					end
					if (is_empty !== t.empty) begin
						$display("%0t: is_empty expected %b actual %b", $time, t.empty, is_empty);
						errors++;
					end
					if (last !== t.last) begin
						$display("%0t: last expected %b actual %b", $time, t.last, last);
						errors++;
					end
				end
			end
			out_stall <= hold_recv || ($urandom_range(99) < recv_stall_pct);
		end
	end

	function automatic cmd_t make_cmd(input logic [2:0] m, input logic [1:0] s,
		input logic [31:0] c, input logic [4:0] e);
		cmd_t r;
		r = '{m, s, c, e};
		return r;
	endfunction

	// random item: mostly inserts, with random, small or extreme coefficients
	function automatic cmd_t random_cmd();
		int pick;
		logic [31:0] c;
		logic [1:0]  s;
		logic [4:0]  e;
		pick = $urandom_range(99);
		s = 2'($urandom);
		e = 5'($urandom);
		case ($urandom_range(3))
			0: c = $urandom;
			1: c = $urandom_range(7) - 3;
			2: c = {$urandom_range(1) ? 32'h8000_0000 : 32'h7fff_ffff};
			default: c = $urandom_range(255);
		endcase
		if (pick < 55) return make_cmd(MODE_INSERT, 2'($urandom_range(1)), c, e);
		if (pick < 60) return make_cmd(MODE_INSERT, s, c, e);
		if (pick < 67) return make_cmd(MODE_ADD, s, c, e);
		if (pick < 72) return make_cmd(MODE_MUL, s, c, e);
		if (pick < 82) return make_cmd(MODE_LIST, s, c, e);
		if (pick < 90) return make_cmd(MODE_COUNT, s, c, e);
		if (pick < 97) return make_cmd(MODE_CLEAR, s, c, e);
		return make_cmd(3'($urandom_range(7, 6)), s, c, e);
	endfunction

	task automatic drain();
		while (pending.size() > 0 || valid || expected_terms.size() > 0) @(posedge clk);
		repeat (200) @(posedge clk);
	endtask

	// stimulus
	initial begin
		for (int i = 0; i < ProdDepth; i++) begin
			if (i < BaseDepth) begin
				shadow_a[i] = 0;
				shadow_b[i] = 0;
				shadow_sum[i] = 0;
			end
			shadow_prod[i] = 0;
		end
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// directed: empty stores, extremes, cancellation, ignored inserts, unused modes
		pending.push_back(make_cmd(MODE_LIST, SEL_A, 0, 0));
		pending.push_back(make_cmd(MODE_COUNT, SEL_PROD, 0, 0));
		pending.push_back(make_cmd(MODE_INSERT, SEL_A, 32'h7fff_ffff, 31));
		pending.push_back(make_cmd(MODE_INSERT, SEL_A, 32'h8000_0000, 0));
		pending.push_back(make_cmd(MODE_INSERT, SEL_B, 32'hffff_ffff, 31));
		pending.push_back(make_cmd(MODE_INSERT, SEL_B, 0, 5));
		pending.push_back(make_cmd(MODE_INSERT, SEL_B, 3, 0));
		pending.push_back(make_cmd(MODE_INSERT, SEL_SUM, 9, 3));
		pending.push_back(make_cmd(MODE_INSERT, SEL_PROD, 9, 3));
		pending.push_back(make_cmd(3'd6, SEL_A, 1, 1));
		pending.push_back(make_cmd(3'd7, SEL_B, 1, 1));
		pending.push_back(make_cmd(MODE_LIST, SEL_A, 0, 0));
		pending.push_back(make_cmd(MODE_COUNT, SEL_B, 0, 0));
		pending.push_back(make_cmd(MODE_ADD, SEL_A, 0, 0));
		pending.push_back(make_cmd(MODE_ADD, SEL_A, 0, 0));
		pending.push_back(make_cmd(MODE_MUL, SEL_A, 0, 0));
		pending.push_back(make_cmd(MODE_MUL, SEL_A, 0, 0));
		pending.push_back(make_cmd(MODE_INSERT, SEL_B, 32'h0000_0001, 31));
		pending.push_back(make_cmd(MODE_LIST, SEL_B, 0, 0));
		pending.push_back(make_cmd(MODE_COUNT, SEL_SUM, 0, 0));
		pending.push_back(make_cmd(MODE_CLEAR, SEL_SUM, 0, 0));
		pending.push_back(make_cmd(MODE_LIST, SEL_SUM, 0, 0));
		pending.push_back(make_cmd(MODE_CLEAR, SEL_PROD, 0, 0));
		pending.push_back(make_cmd(MODE_COUNT, SEL_PROD, 0, 0));
		drain();

		// random phases with varying idle and stall rates
		for (int ph = 0; ph < 4; ph++) begin
			send_idle_pct = (ph == 1 || ph == 3) ? 80 : 0;
			recv_stall_pct = (ph == 2 || ph == 3) ? 80 : 0;
			if (ph == 3) begin
				send_idle_pct = 6;
				recv_stall_pct = 6;
			end
			for (int i = 0; i < 45; i++) pending.push_back(random_cmd());
			drain();
		end

		// long receiver hold-off while commands keep arriving
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_recv = 1;
		for (int i = 0; i < 6; i++)
			pending.push_back(make_cmd(MODE_LIST, 2'($urandom), 0, 0));
		for (int i = 0; i < 4; i++) pending.push_back(random_cmd());
		repeat (3000) @(posedge clk);
		hold_recv = 0;
		drain();

		if (errors == 0 && expected_terms.size() == 0)
			$display("polynomial_term_accumulator_test: done, clean");
		else
			$display("polynomial_term_accumulator_test: done, errors");
		$finish;
	end

	// run limit
	initial begin
		#50000000;
		$display("polynomial_term_accumulator_test: done, errors");
		$finish;
	end

endmodule
